### rtl/rdm_pkg.sv
// ----------------------------------------------------------------------------
// rdm_pkg
// shared constants, codes and fixed-point helpers for the drive mixer
// ----------------------------------------------------------------------------
package rdm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int W_AXIS    = 16;
    localparam int W_CFG     = 15;
    localparam int W_WHEEL   = 20;
    localparam int W_ACC     = 18;
    localparam int W_MUL     = 21;
    localparam int W_PROD    = 2 * W_MUL;
    localparam int W_NUM     = 32;
    localparam int W_DEN     = 18;
    localparam int W_SD      = W_PROD - FRAC_BITS + 1;

    localparam logic [W_CFG-1:0] ONE_Q = W_CFG'(1 << FRAC_BITS);

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEADBAND  = 3'd0,
        CFG_EXPONENT  = 3'd1,
        CFG_THRESHOLD = 3'd2,
        CFG_ALPHA     = 3'd3,
        CFG_FOUR      = 3'd4,
        CFG_INVERT    = 3'd5
    } t_cfg_idx;

    // drive modes
    typedef enum logic [1:0] {
        MODE_TANK      = 2'd0,
        MODE_ARCADE    = 2'd1,
        MODE_CURVATURE = 2'd2,
        MODE_HOLONOMIC = 2'd3
    } t_mode;

    // divider handshake
    typedef struct packed {
        logic             start;
        logic [W_NUM-1:0] num;
        logic [W_DEN-1:0] den;
    } t_div_req;

    // drop fraction bits, rounding half away from zero
    function automatic logic signed [W_SD-1:0] scale_down(input logic signed [W_PROD-1:0] v);
        logic [W_PROD-1:0] m;
        logic [W_PROD-1:0] r;
        m = v[W_PROD-1] ? W_PROD'(-v) : W_PROD'(v);
        r = (m + W_PROD'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[W_PROD-1] ? -$signed(W_SD'(r)) : $signed(W_SD'(r));
    endfunction

endpackage

### rtl/rdm_div.sv
// ----------------------------------------------------------------------------
// rdm_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rdm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rdm_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [rdm_pkg::W_NUM-1:0] o_quot
);
    import rdm_pkg::*;

    localparam int W_CNT = $clog2(W_NUM + 1);

    logic [W_NUM-1:0] r_q, n_q;
    logic [W_DEN-1:0] r_rem, n_rem;
    logic [W_DEN-1:0] r_den;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W_DEN:0]   rem_sh;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_q[W_NUM-1]};
        n_q    = {r_q[W_NUM-2:0], 1'b0};
        n_rem  = rem_sh[W_DEN-1:0];
        if (rem_sh >= {1'b0, r_den}) begin
            n_rem  = W_DEN'(rem_sh - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= W_CNT'(W_NUM);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/robot_drive_mixer.sv
// ----------------------------------------------------------------------------
// robot_drive_mixer
// joystick command to four wheel powers: axis curve, mix, normalize, invert
// ----------------------------------------------------------------------------
// One command is taken at a time; the block is busy until its wheel powers are
// stored in the output register. Each of the three axes takes an S_CV_INIT step
// and, outside the deadband, one pass through the shared 32-step divider, plus a
// multiplier pass per power of the exponent and a final S_CV_POW step to store
// the result; curvature adds the accumulator or angle steps and S_CVEND, and in
// curvature and holonomic modes normalization adds one divider pass per wheel
// when a wheel exceeds full scale. A command may also wait in S_FIN for the
// output register to be taken. Holonomic commands in the two-motor setup are
// taken and give no transfer.
module robot_drive_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [rdm_pkg::W_CFG-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic signed [rdm_pkg::W_AXIS-1:0]   i_first_axis,
    input  logic signed [rdm_pkg::W_AXIS-1:0]   i_second_axis,
    input  logic signed [rdm_pkg::W_AXIS-1:0]   i_third_axis,
    input  logic                                i_quick_turn,
    input  logic                                i_inverted_reverse,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rdm_pkg::W_AXIS-1:0]   o_front_left_power,
    output logic signed [rdm_pkg::W_AXIS-1:0]   o_front_right_power,
    output logic signed [rdm_pkg::W_AXIS-1:0]   o_rear_left_power,
    output logic signed [rdm_pkg::W_AXIS-1:0]   o_rear_right_power
);
    import rdm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CV_INIT = 13'b0000000000010,
        S_CV_DIV  = 13'b0000000000100,
        S_CV_POW  = 13'b0000000001000,
        S_MIX     = 13'b0000000010000,
        S_ACC1    = 13'b0000000100000,
        S_ACC2    = 13'b0000001000000,
        S_ANG     = 13'b0000010000000,
        S_CVEND   = 13'b0000100000000,
        S_NMAX    = 13'b0001000000000,
        S_NDIV    = 13'b0010000000000,
        S_NWAIT   = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } t_state;

    localparam logic signed [W_WHEEL-1:0] ONE_W = W_WHEEL'(1 << FRAC_BITS);

    // configuration
    logic [W_CFG-1:0] r_deadband, r_thr, r_alpha;
    logic [2:0]       r_exp;
    logic             r_four;
    logic [3:0]       r_inv;

    // item and working state
    t_state                     r_state;
    logic signed [W_AXIS-1:0]   r_a [3];
    t_mode                      r_mode;
    logic                       r_quick, r_invrev;
    logic [1:0]                 r_ax;
    logic                       r_neg;
    logic [W_CFG-1:0]           r_p, r_t;
    logic [2:0]                 r_cnt;
    logic signed [W_AXIS-1:0]   r_c [3];
    logic signed [W_ACC-1:0]    r_acc;
    logic signed [W_WHEEL-1:0]  r_ang;
    logic signed [W_WHEEL-1:0]  r_w [4];
    logic [2:0]                 r_n;
    logic [1:0]                 r_ni;
    logic [W_DEN-1:0]           r_mx;
    logic signed [W_PROD-1:0]   r_prod;
    logic                       r_ovalid;
    logic signed [W_AXIS-1:0]   r_out [4];

    logic                       in_xfer;
    logic                       drop_item;
    t_div_req                   div_req;
    logic                       div_done;
    logic [W_NUM-1:0]           div_quot;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= '0;
            r_exp      <= 3'd1;
            r_thr      <= W_CFG'(3277);
            r_alpha    <= W_CFG'(1638);
            r_four     <= 1'b0;
            r_inv      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADBAND:  r_deadband <= i_cfg_data;
                CFG_EXPONENT:  r_exp      <= i_cfg_data[2:0];
                CFG_THRESHOLD: r_thr      <= i_cfg_data;
                CFG_ALPHA:     r_alpha    <= i_cfg_data;
                CFG_FOUR:      r_four     <= i_cfg_data[0];
                CFG_INVERT:    r_inv      <= i_cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign drop_item = (t_mode'(i_mode) == MODE_HOLONOMIC) && !r_four;

    // axis curve front end
    logic signed [W_AXIS-1:0] ax_sel;
    logic signed [W_AXIS:0]   ax_ext;
    logic [W_AXIS:0]          ax_mag;
    logic [W_CFG-1:0]         db, mm, alpha_s;

    always_comb begin
        case (r_ax)
            2'd0:    ax_sel = r_a[0];
            2'd1:    ax_sel = r_a[1];
            default: ax_sel = r_a[2];
        endcase
        ax_ext  = {ax_sel[W_AXIS-1], ax_sel};
        ax_mag  = ax_ext[W_AXIS] ? (W_AXIS+1)'(-ax_ext) : (W_AXIS+1)'(ax_ext);
        db      = (r_deadband > ONE_Q) ? ONE_Q : r_deadband;
        mm      = (ax_mag > (W_AXIS+1)'(ONE_Q)) ? ONE_Q : ax_mag[W_CFG-1:0];
        alpha_s = (r_alpha > ONE_Q) ? ONE_Q : r_alpha;
    end

    // shared multiplier with rounding scaler
    logic signed [W_MUL-1:0]  mul_a, mul_b;
    logic signed [W_PROD-1:0] prod, sd_in;
    logic signed [W_SD-1:0]   sd;
    logic signed [W_WHEEL-1:0] c1_w, c2_w, c3_w, t_mag;

    assign c1_w  = W_WHEEL'(r_c[0]);
    assign c2_w  = W_WHEEL'(r_c[1]);
    assign c3_w  = W_WHEEL'(r_c[2]);
    assign t_mag = c1_w[W_WHEEL-1] ? -c1_w : c1_w;

    always_comb begin
        case (r_state)
            S_CV_POW: begin
                mul_a = $signed(W_MUL'(r_p));
                mul_b = $signed(W_MUL'(r_t));
            end
            S_ACC1: begin
                mul_a = $signed(W_MUL'(ONE_Q - alpha_s));
                mul_b = W_MUL'(r_acc);
            end
            S_ACC2: begin
                mul_a = $signed(W_MUL'(alpha_s));
                mul_b = W_MUL'(c2_w) <<< 1;
            end
            S_ANG: begin
                mul_a = W_MUL'(t_mag);
                mul_b = W_MUL'(c2_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod  = mul_a * mul_b;
        sd_in = (r_state == S_ACC2) ? (r_prod + prod) : prod;
        sd    = scale_down(sd_in);
    end

    // wheel magnitudes and largest one
    logic [W_WHEEL-1:0] w_mag [4];
    logic [W_WHEEL-1:0] mx;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = r_w[i][W_WHEEL-1] ? W_WHEEL'(-r_w[i]) : W_WHEEL'(r_w[i]);
        end
        mx = '0;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < r_n) && (w_mag[i] > mx)) begin
                mx = w_mag[i];
            end
        end
    end

    // divider request
    always_comb begin
        div_req = '0;
        if (r_state == S_CV_INIT) begin
            div_req.start = (ax_sel != '0) && (ax_mag >= (W_AXIS+1)'(db)) && (db < ONE_Q);
            div_req.num   = W_NUM'(mm - db) << FRAC_BITS;
            div_req.den   = W_DEN'(ONE_Q - db);
        end else if (r_state == S_NDIV) begin
            div_req.start = 1'b1;
            div_req.num   = (W_NUM'(w_mag[r_ni]) << FRAC_BITS) + W_NUM'(r_mx >> 1);
            div_req.den   = r_mx;
        end
    end

    rdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // mixing rules
    logic signed [W_WHEEL-1:0] big, mi, l, rt, acc_w, acc_dec;
    logic                      back;

    always_comb begin
        big   = (t_mag > (c2_w[W_WHEEL-1] ? -c2_w : c2_w)) ? t_mag
              : (c2_w[W_WHEEL-1] ? -c2_w : c2_w);
        mi    = (c1_w > 0) ? big : -big;
        acc_w = W_WHEEL'(r_acc);
        if (acc_w > ONE_W) begin
            acc_dec = acc_w - ONE_W;
        end else if (acc_w < -ONE_W) begin
            acc_dec = acc_w + ONE_W;
        end else begin
            acc_dec = '0;
        end
        back = c1_w[W_WHEEL-1] && r_invrev;
        if (back) begin
            l  = -(c1_w - r_ang);
            rt = -(c1_w + r_ang);
        end else begin
            l  = c1_w + r_ang;
            rt = c1_w - r_ang;
        end
        if (r_quick) begin
            if (l > ONE_W) begin
                rt = rt - (l - ONE_W);
                l  = ONE_W;
            end else if (rt > ONE_W) begin
                l  = l - (rt - ONE_W);
                rt = ONE_W;
            end else if (l < -ONE_W) begin
                rt = rt - (l + ONE_W);
                l  = -ONE_W;
            end else if (rt < -ONE_W) begin
                l  = l - (rt + ONE_W);
                rt = -ONE_W;
            end
        end
    end

    logic fin_go;
    assign fin_go = (r_state == S_FIN) && (!r_ovalid || i_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ax <= '0;
                    if (in_xfer && !drop_item) begin
                        r_state <= S_CV_INIT;
                    end
                end
                S_CV_INIT: begin
                    if (ax_sel == '0 || ax_mag < (W_AXIS+1)'(db)) begin
                        r_c[r_ax] <= '0;
                        if (r_ax == 2'd2) begin
                            r_state <= S_MIX;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                        end
                    end else begin
                        r_neg <= ax_sel[W_AXIS-1];
                        r_p   <= ONE_Q;
                        r_cnt <= r_exp;
                        if (db < ONE_Q) begin
                            r_state <= S_CV_DIV;
                        end else begin
                            r_t     <= '0;
                            r_state <= S_CV_POW;
                        end
                    end
                end
                S_CV_DIV: begin
                    if (div_done) begin
                        r_t     <= div_quot[W_CFG-1:0];
                        r_state <= S_CV_POW;
                    end
                end
                S_CV_POW: begin
                    if (r_cnt == '0) begin
                        r_c[r_ax] <= r_neg ? -$signed(W_AXIS'(r_p)) : $signed(W_AXIS'(r_p));
                        if (r_ax == 2'd2) begin
                            r_state <= S_MIX;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_CV_INIT;
                        end
                    end else begin
                        r_p   <= W_CFG'(sd);
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MIX: begin
                    case (r_mode)
                        MODE_TANK: begin
                            r_w[0]  <= c1_w;
                            r_w[1]  <= c3_w;
                            r_w[2]  <= c1_w;
                            r_w[3]  <= c3_w;
                            r_state <= S_FIN;
                        end
                        MODE_ARCADE: begin
                            if (c1_w > 0) begin
                                r_w[0] <= (c2_w > 0) ? mi : c1_w + c2_w;
                                r_w[1] <= (c2_w > 0) ? c1_w - c2_w : mi;
                                r_w[2] <= (c2_w > 0) ? mi : c1_w + c2_w;
                                r_w[3] <= (c2_w > 0) ? c1_w - c2_w : mi;
                            end else if (c2_w > 0) begin
                                r_w[0] <= r_invrev ? mi : c1_w + c2_w;
                                r_w[1] <= r_invrev ? c1_w + c2_w : mi;
                                r_w[2] <= r_invrev ? mi : c1_w + c2_w;
                                r_w[3] <= r_invrev ? c1_w + c2_w : mi;
                            end else begin
                                r_w[0] <= r_invrev ? c1_w - c2_w : mi;
                                r_w[1] <= r_invrev ? mi : c1_w - c2_w;
                                r_w[2] <= r_invrev ? c1_w - c2_w : mi;
                                r_w[3] <= r_invrev ? mi : c1_w - c2_w;
                            end
                            r_state <= S_FIN;
                        end
                        MODE_CURVATURE: begin
                            if (r_quick) begin
                                r_ang <= c2_w;
                                if (t_mag < $signed(W_WHEEL'(r_thr))) begin
                                    r_state <= S_ACC1;
                                end else begin
                                    r_state <= S_CVEND;
                                end
                            end else begin
                                r_state <= S_ANG;
                            end
                        end
                        default: begin
                            r_w[0]  <= c3_w + c1_w + c2_w;
                            r_w[1]  <= -c3_w + c1_w - c2_w;
                            r_w[2]  <= -c3_w + c1_w + c2_w;
                            r_w[3]  <= c3_w + c1_w - c2_w;
                            r_n     <= 3'd4;
                            r_state <= S_NMAX;
                        end
                    endcase
                end
                S_ACC1: begin
                    r_prod  <= prod;
                    r_state <= S_ACC2;
                end
                S_ACC2: begin
                    r_acc   <= W_ACC'(sd);
                    r_state <= S_CVEND;
                end
                S_ANG: begin
                    r_ang   <= W_WHEEL'(sd) - acc_w;
                    r_state <= S_CVEND;
                end
                S_CVEND: begin
                    r_acc   <= W_ACC'(acc_dec);
                    r_w[0]  <= l;
                    r_w[1]  <= rt;
                    r_w[2]  <= '0;
                    r_w[3]  <= '0;
                    r_n     <= 3'd2;
                    r_state <= S_NMAX;
                end
                S_NMAX: begin
                    r_mx <= W_DEN'(mx);
                    r_ni <= '0;
                    if (mx > W_WHEEL'(ONE_Q)) begin
                        r_state <= S_NDIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_NDIV: begin
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (div_done) begin
                        r_w[r_ni] <= r_w[r_ni][W_WHEEL-1] ? -$signed(W_WHEEL'(div_quot))
                                                          : $signed(W_WHEEL'(div_quot));
                        if (3'(r_ni) + 3'd1 == r_n) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ni    <= r_ni + 1'b1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // in curvature the rear pair copies the front pair
            if (r_state == S_FIN && r_mode == MODE_CURVATURE && !fin_go) begin
                r_w[2] <= r_w[0];
                r_w[3] <= r_w[1];
            end
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a[0]   <= i_first_axis;
            r_a[1]   <= i_second_axis;
            r_a[2]   <= i_third_axis;
            r_mode   <= t_mode'(i_mode);
            r_quick  <= i_quick_turn;
            r_invrev <= i_inverted_reverse;
        end
    end

    // output register
    logic signed [W_WHEEL-1:0] w_fin [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_mode == MODE_CURVATURE && i >= 2) begin
                w_fin[i] = r_w[i-2];
            end else begin
                w_fin[i] = r_w[i];
            end
            if (i >= 2 && !r_four) begin
                w_fin[i] = '0;
            end
            if (r_inv[i]) begin
                w_fin[i] = -w_fin[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_go) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= W_AXIS'(w_fin[i]);
            end
        end
    end

    assign o_valid             = r_ovalid;
    assign o_front_left_power  = r_out[0];
    assign o_front_right_power = r_out[1];
    assign o_rear_left_power   = r_out[2];
    assign o_rear_right_power  = r_out[3];

    // checks
    a_state_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_div_start_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == S_CV_INIT || r_state == S_NDIV))
        else $error("divider started outside a divide step");

    a_fin_loads_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished item did not reach the output register");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !drop_item) |=> !o_ready)
        else $error("block ready right after taking a command");

endmodule
